/* rtl/lax_friedrichs_lin_euler_flux_defines.svh */
// Assertion macros shared by the flux unit RTL.
`ifndef LAX_FRIEDRICHS_LIN_EULER_FLUX_DEFINES_SVH
`define LAX_FRIEDRICHS_LIN_EULER_FLUX_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define LFE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LFE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lfe_pkg.sv */
// Types, constants and fixed-point helpers for the Lax-Friedrichs flux unit.
package lfe_pkg;

  localparam int NUM_FIELDS = 4;
  localparam int DIV_LAT    = 34;
  localparam int BACK_LAT   = 7;
  localparam int LAT        = DIV_LAT + BACK_LAT;
  localparam int SOUND_W    = 24;

  localparam int F_RHO = 0;
  localparam int F_P   = 1;
  localparam int F_U   = 2;
  localparam int F_V   = 3;

  localparam logic [2:0] REG_MEAN_DENSITY  = 3'd0;
  localparam logic [2:0] REG_MEAN_PRESSURE = 3'd1;
  localparam logic [2:0] REG_MEAN_VEL_X    = 3'd2;
  localparam logic [2:0] REG_MEAN_VEL_Y    = 3'd3;
  localparam logic [2:0] REG_HEAT_RATIO    = 3'd4;

  localparam logic [30:0] RST_MEAN_DENSITY  = 31'd65536;
  localparam logic [30:0] RST_MEAN_PRESSURE = 31'd520127;
  localparam logic [31:0] RST_MEAN_VEL      = 32'd0;
  localparam logic [18:0] RST_HEAT_RATIO    = 19'd91750;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic               busy;
    q_t                 pg;
    logic [SOUND_W-1:0] sound;
  } cfg_status_t;

  localparam q_t Q_MAX = 32'sh7FFFFFFF;
  localparam q_t Q_MIN = 32'sh80000000;

  function automatic q_t sat32(input wide_t x);
    if (x > 66'sd2147483647) begin
      return Q_MAX;
    end else if (x < -66'sd2147483648) begin
      return Q_MIN;
    end
    return x[31:0];
  endfunction

  function automatic prod_t mul_full(input q_t a, input q_t b);
    return 64'(a) * 64'(b);
  endfunction

  // Round half up, then saturate.
  function automatic q_t qmul(input prod_t p);
    wide_t t;
    t = (66'(p) + 66'sd32768) >>> 16;
    return sat32(t);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic q_t lmax_of(input q_t un, input logic [SOUND_W-1:0] c);
    wide_t u;
    wide_t a;
    u = 66'(un);
    a = (u < 0) ? -u : u;
    return sat32(a + 66'($signed({1'b0, c})));
  endfunction

  function automatic q_t half_sat(input logic signed [33:0] s);
    wide_t t;
    t = (66'(s) + 66'sd1) >>> 1;
    return sat32(t);
  endfunction

endpackage

/* rtl/lax_friedrichs_lin_euler_flux.sv */
// Lax-Friedrichs flux unit for the linearised 2-D Euler equations, Q16.16 fixed point.
// Result: the strobe out_valid marks an item's result once it has passed the
//   34 divider stages and then the 7 flux stages.
// Throughput: one item per cycle while busy is low; the receiver cannot stall, so
//   the pipeline never holds. Reset and every register write start a recalculation
//   of gamma*p and the sound speed; busy stays high throughout and no item is taken.
`include "lax_friedrichs_lin_euler_flux_defines.svh"
module lax_friedrichs_lin_euler_flux import lfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  q_t          in_left_density_pert,
  input  q_t          in_left_pressure_pert,
  input  q_t          in_left_velx_pert,
  input  q_t          in_left_vely_pert,
  input  q_t          in_right_density_pert,
  input  q_t          in_right_pressure_pert,
  input  q_t          in_right_velx_pert,
  input  q_t          in_right_vely_pert,
  input  logic signed [17:0] in_normal_x,
  input  logic signed [17:0] in_normal_y,
  output logic        out_valid,
  output q_t          out_flux_density,
  output q_t          out_flux_pressure,
  output q_t          out_flux_velx,
  output q_t          out_flux_vely,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAST = DIV_LAT - 1;

  // ---------------------------------------------------------------------------
  // Mean-flow registers behind the APB port
  // ---------------------------------------------------------------------------
  logic [30:0] mean_density_r;
  logic [30:0] mean_pressure_r;
  q_t          mean_vel_x_r;
  q_t          mean_vel_y_r;
  logic [18:0] heat_ratio_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [30:0] rho_eff;
  q_t          rho_s;
  cfg_status_t cfg_st;
  logic        accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_density_r  <= RST_MEAN_DENSITY;
      mean_pressure_r <= RST_MEAN_PRESSURE;
      mean_vel_x_r    <= RST_MEAN_VEL;
      mean_vel_y_r    <= RST_MEAN_VEL;
      heat_ratio_r    <= RST_HEAT_RATIO;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MEAN_DENSITY:  mean_density_r  <= pwdata[30:0];
        REG_MEAN_PRESSURE: mean_pressure_r <= pwdata[30:0];
        REG_MEAN_VEL_X:    mean_vel_x_r    <= pwdata;
        REG_MEAN_VEL_Y:    mean_vel_y_r    <= pwdata;
        REG_HEAT_RATIO:    heat_ratio_r    <= pwdata[18:0];
        default:           heat_ratio_r    <= heat_ratio_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MEAN_DENSITY:  prdata = {1'b0, mean_density_r};
      REG_MEAN_PRESSURE: prdata = {1'b0, mean_pressure_r};
      REG_MEAN_VEL_X:    prdata = mean_vel_x_r;
      REG_MEAN_VEL_Y:    prdata = mean_vel_y_r;
      REG_HEAT_RATIO:    prdata = {13'd0, heat_ratio_r};
      default:           prdata = '0;
    endcase
  end

  // A zero mean density stands for the smallest positive density.
  assign rho_eff = (mean_density_r == '0) ? 31'd1 : mean_density_r;
  assign rho_s   = {1'b0, rho_eff};

  // Recalculate gamma*p and the sound speed after reset and after any write.
  lfe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .kick   (cfg_wr),
    .rho    (rho_eff),
    .pres   (mean_pressure_r),
    .gamma  (heat_ratio_r),
    .status (cfg_st)
  );

  assign busy   = cfg_st.busy;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Front end: pressure / density dividers with a matching delay line
  // ---------------------------------------------------------------------------
  q_t                dl_l_r  [DIV_LAT][NUM_FIELDS];
  q_t                dl_r_r  [DIV_LAT][NUM_FIELDS];
  logic signed [17:0] dl_nx_r [DIV_LAT];
  logic signed [17:0] dl_ny_r [DIV_LAT];
  logic [DIV_LAT-1:0] dv_r;
  q_t                qr_l, qr_r;

  lfe_div u_div_l (
    .clk  (clk),
    .num  (in_left_pressure_pert),
    .rho  (rho_eff),
    .quot (qr_l)
  );

  lfe_div u_div_r (
    .clk  (clk),
    .num  (in_right_pressure_pert),
    .rho  (rho_eff),
    .quot (qr_r)
  );

  // Payload moves every cycle; the valid bits say which slots hold an item.
  always_ff @(posedge clk) begin
    dl_l_r[0][F_RHO] <= in_left_density_pert;
    dl_l_r[0][F_P]   <= in_left_pressure_pert;
    dl_l_r[0][F_U]   <= in_left_velx_pert;
    dl_l_r[0][F_V]   <= in_left_vely_pert;
    dl_r_r[0][F_RHO] <= in_right_density_pert;
    dl_r_r[0][F_P]   <= in_right_pressure_pert;
    dl_r_r[0][F_U]   <= in_right_velx_pert;
    dl_r_r[0][F_V]   <= in_right_vely_pert;
    dl_nx_r[0]       <= in_normal_x;
    dl_ny_r[0]       <= in_normal_y;
    for (int s = 1; s < DIV_LAT; s++) begin
      dl_l_r[s]  <= dl_l_r[s-1];
      dl_r_r[s]  <= dl_r_r[s-1];
      dl_nx_r[s] <= dl_nx_r[s-1];
      dl_ny_r[s] <= dl_ny_r[s-1];
    end
  end

  logic [BACK_LAT-1:0] bv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      bv_r <= '0;
    end else begin
      dv_r <= {dv_r[DIV_LAT-2:0], accept};
      bv_r <= {bv_r[BACK_LAT-2:0], dv_r[LAST]};
    end
  end

  // ---------------------------------------------------------------------------
  // Back end: flux stages E1..E7
  // ---------------------------------------------------------------------------
  q_t nx_last, ny_last;
  assign nx_last = 32'(dl_nx_r[LAST]);
  assign ny_last = 32'(dl_ny_r[LAST]);

  // E1: products against the normal, state jump.
  prod_t e1_p_u0nx_r, e1_p_u1ny_r;
  prod_t e1_p_wl_r [2];
  prod_t e1_p_wr_r [2];
  prod_t e1_p_ql_r [2];
  prod_t e1_p_qr_r [2];
  q_t    e1_d_r  [NUM_FIELDS];
  q_t    e1_sl_r [NUM_FIELDS];
  q_t    e1_sr_r [NUM_FIELDS];

  always_ff @(posedge clk) begin
    e1_p_u0nx_r  <= mul_full(mean_vel_x_r, nx_last);
    e1_p_u1ny_r  <= mul_full(mean_vel_y_r, ny_last);
    e1_p_wl_r[0] <= mul_full(dl_l_r[LAST][F_U], nx_last);
    e1_p_wl_r[1] <= mul_full(dl_l_r[LAST][F_V], ny_last);
    e1_p_wr_r[0] <= mul_full(dl_r_r[LAST][F_U], nx_last);
    e1_p_wr_r[1] <= mul_full(dl_r_r[LAST][F_V], ny_last);
    e1_p_ql_r[0] <= mul_full(qr_l, nx_last);
    e1_p_ql_r[1] <= mul_full(qr_l, ny_last);
    e1_p_qr_r[0] <= mul_full(qr_r, nx_last);
    e1_p_qr_r[1] <= mul_full(qr_r, ny_last);
    for (int k = 0; k < NUM_FIELDS; k++) begin
      e1_d_r[k]  <= qsub(dl_l_r[LAST][k], dl_r_r[LAST][k]);
      e1_sl_r[k] <= dl_l_r[LAST][k];
      e1_sr_r[k] <= dl_r_r[LAST][k];
    end
  end

  // E2: normal velocities and the pressure-gradient terms.
  q_t e2_un_r, e2_wnl_r, e2_wnr_r;
  q_t e2_gl_r [2];
  q_t e2_gr_r [2];
  q_t e2_d_r  [NUM_FIELDS];
  q_t e2_sl_r [NUM_FIELDS];
  q_t e2_sr_r [NUM_FIELDS];

  always_ff @(posedge clk) begin
    e2_un_r  <= qadd(qmul(e1_p_u0nx_r), qmul(e1_p_u1ny_r));
    e2_wnl_r <= qadd(qmul(e1_p_wl_r[0]), qmul(e1_p_wl_r[1]));
    e2_wnr_r <= qadd(qmul(e1_p_wr_r[0]), qmul(e1_p_wr_r[1]));
    for (int j = 0; j < 2; j++) begin
      e2_gl_r[j] <= qmul(e1_p_ql_r[j]);
      e2_gr_r[j] <= qmul(e1_p_qr_r[j]);
    end
    e2_d_r  <= e1_d_r;
    e2_sl_r <= e1_sl_r;
    e2_sr_r <= e1_sr_r;
  end

  // E3: advection and coupling products; largest wave speed.
  prod_t e3_pl_r [6];
  prod_t e3_pr_r [6];
  q_t    e3_lmax_r;
  q_t    e3_gl_r [2];
  q_t    e3_gr_r [2];
  q_t    e3_d_r  [NUM_FIELDS];

  always_ff @(posedge clk) begin
    e3_pl_r[0] <= mul_full(e2_un_r, e2_sl_r[F_RHO]);
    e3_pl_r[1] <= mul_full(rho_s, e2_wnl_r);
    e3_pl_r[2] <= mul_full(e2_un_r, e2_sl_r[F_P]);
    e3_pl_r[3] <= mul_full(cfg_st.pg, e2_wnl_r);
    e3_pl_r[4] <= mul_full(e2_un_r, e2_sl_r[F_U]);
    e3_pl_r[5] <= mul_full(e2_un_r, e2_sl_r[F_V]);
    e3_pr_r[0] <= mul_full(e2_un_r, e2_sr_r[F_RHO]);
    e3_pr_r[1] <= mul_full(rho_s, e2_wnr_r);
    e3_pr_r[2] <= mul_full(e2_un_r, e2_sr_r[F_P]);
    e3_pr_r[3] <= mul_full(cfg_st.pg, e2_wnr_r);
    e3_pr_r[4] <= mul_full(e2_un_r, e2_sr_r[F_U]);
    e3_pr_r[5] <= mul_full(e2_un_r, e2_sr_r[F_V]);
    e3_lmax_r  <= lmax_of(e2_un_r, cfg_st.sound);
    e3_gl_r    <= e2_gl_r;
    e3_gr_r    <= e2_gr_r;
    e3_d_r     <= e2_d_r;
  end

  // E4: one-sided normal fluxes.
  q_t e4_fl_r [NUM_FIELDS];
  q_t e4_fr_r [NUM_FIELDS];
  q_t e4_d_r  [NUM_FIELDS];
  q_t e4_lmax_r;

  always_ff @(posedge clk) begin
    e4_fl_r[F_RHO] <= qadd(qmul(e3_pl_r[0]), qmul(e3_pl_r[1]));
    e4_fl_r[F_P]   <= qadd(qmul(e3_pl_r[2]), qmul(e3_pl_r[3]));
    e4_fl_r[F_U]   <= qadd(e3_gl_r[0], qmul(e3_pl_r[4]));
    e4_fl_r[F_V]   <= qadd(e3_gl_r[1], qmul(e3_pl_r[5]));
    e4_fr_r[F_RHO] <= qadd(qmul(e3_pr_r[0]), qmul(e3_pr_r[1]));
    e4_fr_r[F_P]   <= qadd(qmul(e3_pr_r[2]), qmul(e3_pr_r[3]));
    e4_fr_r[F_U]   <= qadd(e3_gr_r[0], qmul(e3_pr_r[4]));
    e4_fr_r[F_V]   <= qadd(e3_gr_r[1], qmul(e3_pr_r[5]));
    e4_d_r         <= e3_d_r;
    e4_lmax_r      <= e3_lmax_r;
  end

  // E5: dissipation products and the central sum.
  prod_t              e5_t_r  [NUM_FIELDS];
  logic signed [32:0] e5_fs_r [NUM_FIELDS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      e5_t_r[k]  <= mul_full(e4_lmax_r, e4_d_r[k]);
      e5_fs_r[k] <= 33'(e4_fl_r[k]) + 33'(e4_fr_r[k]);
    end
  end

  // E6: exact sum of both fluxes and the dissipation.
  logic signed [33:0] e6_s_r [NUM_FIELDS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      e6_s_r[k] <= 34'(e5_fs_r[k]) + 34'(qmul(e5_t_r[k]));
    end
  end

  // E7: halve with round half up, saturate, drive the result.
  q_t e7_f_r [NUM_FIELDS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      e7_f_r[k] <= half_sat(e6_s_r[k]);
    end
  end

  assign out_valid         = bv_r[BACK_LAT-1];
  assign out_flux_density  = e7_f_r[F_RHO];
  assign out_flux_pressure = e7_f_r[F_P];
  assign out_flux_velx     = e7_f_r[F_U];
  assign out_flux_vely     = e7_f_r[F_V];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LFE_ASSERT_NEXT(a_wr_busy, clk, rst_n, cfg_wr, busy, "register write did not raise busy")
  `LFE_ASSERT_SAME(a_out_src, clk, rst_n, out_valid, $past(accept, LAT), "result without item")
  `LFE_ASSERT_SAME(a_out_back, clk, rst_n, out_valid, $past(dv_r[LAST], BACK_LAT), "flux stage slip")

endmodule

/* rtl/lfe_div.sv */
// Pipelined restoring divider: saturated Q16.16 quotient of a value by the mean density.
module lfe_div import lfe_pkg::*; (
  input  logic        clk,
  input  q_t          num,
  input  logic [30:0] rho,
  output q_t          quot
);

  localparam int STEPS = 32;

  logic [31:0] rem_r [STEPS+1];
  logic [31:0] low_r [STEPS+1];
  logic [31:0] quo_r [STEPS+1];
  logic        ovf_r [STEPS+1];
  logic        neg_r [STEPS+1];
  q_t          quot_r;

  logic [31:0] mag;
  assign mag = num[31] ? 32'(-33'(num)) : 32'(num);

  // Prepare: the bits above 2^32 of the shifted magnitude decide overflow.
  always_ff @(posedge clk) begin
    rem_r[0] <= {16'd0, mag[31:16]};
    low_r[0] <= {mag[15:0], 16'd0};
    quo_r[0] <= '0;
    ovf_r[0] <= ({15'd0, mag[31:16]} >= rho);
    neg_r[0] <= num[31];
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic [32:0] trial;
    logic        take;
    assign trial = {rem_r[i-1], low_r[i-1][31]};
    assign take  = (trial >= {2'b00, rho});
    always_ff @(posedge clk) begin
      rem_r[i] <= take ? 32'(trial - {2'b00, rho}) : trial[31:0];
      low_r[i] <= {low_r[i-1][30:0], 1'b0};
      quo_r[i] <= {quo_r[i-1][30:0], take};
      ovf_r[i] <= ovf_r[i-1];
      neg_r[i] <= neg_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_r[STEPS]) begin
      if (ovf_r[STEPS] || (quo_r[STEPS] > 32'h80000000)) begin
        quot_r <= Q_MIN;
      end else begin
        quot_r <= 32'(-33'({1'b0, quo_r[STEPS]}));
      end
    end else begin
      if (ovf_r[STEPS] || quo_r[STEPS][31]) begin
        quot_r <= Q_MAX;
      end else begin
        quot_r <= quo_r[STEPS];
      end
    end
  end

  assign quot = quot_r;

endmodule

/* rtl/lfe_cfg.sv */
// Sequencer deriving gamma*p and the sound speed from the mean-flow registers.
module lfe_cfg import lfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        kick,
  input  logic [30:0] rho,
  input  logic [30:0] pres,
  input  logic [18:0] gamma,
  output cfg_status_t status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SETUP = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;

  localparam logic [5:0] MUL_LAST  = 6'd18;
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [5:0] SQRT_LAST = 6'd23;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [49:0] acc_r, mcand_r;
  logic [18:0] mplier_r;
  logic [47:0] num_r, quo_r;
  logic [31:0] rem_r;
  logic [47:0] sq_v_r, sq_res_r, sq_bit_r;
  q_t          pg_r;
  logic [SOUND_W-1:0] sound_r;

  logic [50:0] rnd;
  logic [34:0] rnd_sh;
  logic [32:0] dtrial;
  logic        dtake;
  logic [47:0] sq_sum;
  logic [30:0] ratio;

  assign rnd    = {1'b0, acc_r} + 51'd32768;
  assign rnd_sh = rnd[50:16];
  assign dtrial = {rem_r, num_r[47]};
  assign dtake  = (dtrial >= {2'b00, rho});
  assign sq_sum = sq_res_r + sq_bit_r;
  assign ratio  = (quo_r[47:31] != '0) ? 31'h7FFFFFFF : quo_r[30:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:  state_nxt = ST_IDLE;
      ST_LOAD: begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (kick) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        acc_r    <= '0;
        mcand_r  <= {19'd0, pres};
        mplier_r <= gamma;
      end
      ST_MUL: begin
        acc_r    <= mplier_r[0] ? acc_r + mcand_r : acc_r;
        mcand_r  <= {mcand_r[48:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[18:1]};
      end
      ST_ROUND: begin
        pg_r  <= (rnd_sh[34:31] != '0) ? Q_MAX : {1'b0, rnd_sh[30:0]};
        num_r <= {((rnd_sh[34:31] != '0) ? 32'h7FFFFFFF : {1'b0, rnd_sh[30:0]}), 16'd0};
        rem_r <= '0;
        quo_r <= '0;
      end
      ST_DIV: begin
        rem_r <= dtake ? 32'(dtrial - {2'b00, rho}) : dtrial[31:0];
        num_r <= {num_r[46:0], 1'b0};
        quo_r <= {quo_r[46:0], dtake};
      end
      ST_SETUP: begin
        sq_v_r   <= {1'b0, ratio, 16'd0};
        sq_res_r <= '0;
        sq_bit_r <= 48'h1 << 46;
      end
      ST_SQRT: begin
        if (sq_v_r >= sq_sum) begin
          sq_v_r   <= sq_v_r - sq_sum;
          sq_res_r <= {1'b0, sq_res_r[47:1]} + sq_bit_r;
        end else begin
          sq_res_r <= {1'b0, sq_res_r[47:1]};
        end
        sq_bit_r <= {2'b00, sq_bit_r[47:2]};
        if (cnt_r == SQRT_LAST) begin
          sound_r <= (sq_v_r >= sq_sum) ?
                     SOUND_W'({1'b0, sq_res_r[47:1]} + sq_bit_r) :
                     SOUND_W'({1'b0, sq_res_r[47:1]});
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign status.busy  = (state_r != ST_IDLE);
  assign status.pg    = pg_r;
  assign status.sound = sound_r;

endmodule

/* test/lax_friedrichs_lin_euler_flux_test.sv */
// Self-checking testbench for the Lax-Friedrichs linearised Euler flux unit.
`timescale 1ns / 1ps
module lax_friedrichs_lin_euler_flux_test;
  import lfe_pkg::*;

  // One edge quadrature point: both perturbation states and the edge normal.
  typedef struct {
    q_t                 wl [NUM_FIELDS];
    q_t                 wr [NUM_FIELDS];
    logic signed [17:0] nx;
    logic signed [17:0] ny;
  } edge_point_t;

  typedef struct {
    q_t f [NUM_FIELDS];
  } flux_t;

  // Mirrors the mean flow registers and predicts the flux of each accepted point.
  class flux_scoreboard;
    longint mean_rho, mean_p, mean_u0, mean_u1, gamma;
    flux_t  expected_flux [$];
    int     errors;

    function new();
      mean_rho = 65536;
      mean_p   = 520127;
      mean_u0  = 0;
      mean_u1  = 0;
      gamma    = 91750;
      errors   = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      case (idx)
        REG_MEAN_DENSITY:  mean_rho = longint'(v[30:0]);
        REG_MEAN_PRESSURE: mean_p   = longint'(v[30:0]);
        REG_MEAN_VEL_X:    mean_u0  = longint'($signed(v));
        REG_MEAN_VEL_Y:    mean_u1  = longint'($signed(v));
        REG_HEAT_RATIO:    gamma    = longint'(v[18:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint fx_mul(longint x, longint y);
      return clip((x * y + 32768) >>> 16);
    endfunction

    function longint fx_add(longint x, longint y);
      return clip(x + y);
    endfunction

    function longint fx_div(longint x, longint y);
      if (y == 0) y = 1;
      return clip((x * 65536) / y);
    endfunction

    function longint root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function int pending();
      return expected_flux.size();
    endfunction

    function void note_point(edge_point_t pt);
      longint w [2][NUM_FIELDS];
      longint fs [2][NUM_FIELDS];
      longint nx, ny, rho, pg, un, wn, qr, ratio, snd, lmax, d, t, s;
      flux_t  res;
      nx = longint'(pt.nx);
      ny = longint'(pt.ny);
      for (int k = 0; k < NUM_FIELDS; k++) begin
        w[0][k] = longint'(pt.wl[k]);
        w[1][k] = longint'(pt.wr[k]);
      end
      // A zero mean density behaves as the smallest positive density.
      rho = (mean_rho > 0) ? mean_rho : 1;
      pg  = fx_mul(mean_p, gamma);
      un  = fx_add(fx_mul(mean_u0, nx), fx_mul(mean_u1, ny));
      for (int sd = 0; sd < 2; sd++) begin
        wn = fx_add(fx_mul(w[sd][F_U], nx), fx_mul(w[sd][F_V], ny));
        qr = fx_div(w[sd][F_P], rho);
        fs[sd][F_RHO] = fx_add(fx_mul(un, w[sd][F_RHO]), fx_mul(rho, wn));
        fs[sd][F_P]   = fx_add(fx_mul(un, w[sd][F_P]), fx_mul(pg, wn));
        fs[sd][F_U]   = fx_add(fx_mul(qr, nx), fx_mul(un, w[sd][F_U]));
        fs[sd][F_V]   = fx_add(fx_mul(qr, ny), fx_mul(un, w[sd][F_V]));
      end
      ratio = fx_div(pg, rho);
      if (ratio < 0) ratio = 0;
      snd  = root(longint'(ratio) << 16);
      lmax = clip(((un < 0) ? -un : un) + snd);
      for (int k = 0; k < NUM_FIELDS; k++) begin
        d = fx_add(w[0][k], -w[1][k]);
        t = fx_mul(lmax, d);
        s = fs[0][k] + fs[1][k] + t;
        res.f[k] = q_t'(clip((s + 1) >>> 1));
      end
      expected_flux = {expected_flux, res};
    endfunction

    function void check_flux(flux_t got);
      flux_t want;
      string names [NUM_FIELDS];
      names = '{"flux_density", "flux_pressure", "flux_velx", "flux_vely"};
      if (expected_flux.size() == 0) begin
        $error("flux result with no point outstanding");
        errors++;
        return;
      end
      want = expected_flux.pop_front();
      for (int k = 0; k < NUM_FIELDS; k++) begin
        if (got.f[k] !== want.f[k]) begin
          $error("%s: expected %0d, got %0d", names[k], want.f[k], got.f[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  q_t                 in_wl [NUM_FIELDS];
  q_t                 in_wr [NUM_FIELDS];
  logic signed [17:0] in_nx = '0;
  logic signed [17:0] in_ny = '0;
  logic               out_valid;
  q_t                 out_flux_density, out_flux_pressure, out_flux_velx, out_flux_vely;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  flux_scoreboard sb = new();
  int             idle_pct;

  initial begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      in_wl[k] = '0;
      in_wr[k] = '0;
    end
  end

  lax_friedrichs_lin_euler_flux DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_left_density_pert(in_wl[F_RHO]), .in_left_pressure_pert(in_wl[F_P]),
    .in_left_velx_pert(in_wl[F_U]), .in_left_vely_pert(in_wl[F_V]),
    .in_right_density_pert(in_wr[F_RHO]), .in_right_pressure_pert(in_wr[F_P]),
    .in_right_velx_pert(in_wr[F_U]), .in_right_vely_pert(in_wr[F_V]),
    .in_normal_x(in_nx), .in_normal_y(in_ny),
    .out_valid(out_valid), .out_flux_density(out_flux_density),
    .out_flux_pressure(out_flux_pressure), .out_flux_velx(out_flux_velx),
    .out_flux_vely(out_flux_vely),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note every point the unit takes; values seen here are those before the edge.
  always @(posedge clk) begin
    edge_point_t pt;
    if (rst_n && start && !busy) begin
      pt.wl = in_wl;
      pt.wr = in_wr;
      pt.nx = in_nx;
      pt.ny = in_ny;
      sb.note_point(pt);
    end
  end

  // Results cannot be held off: take each one in the cycle it is strobed.
  always @(posedge clk) begin
    flux_t got;
    if (rst_n && out_valid) begin
      got.f[F_RHO] = out_flux_density;
      got.f[F_P]   = out_flux_pressure;
      got.f[F_U]   = out_flux_velx;
      got.f[F_V]   = out_flux_vely;
      sb.check_flux(got);
    end
  end

  // Present a point and hold start until the unit takes it; leave start high
  // unless an idle gap follows, so points stream one per cycle while busy is low.
  task automatic send_point(edge_point_t pt);
    in_wl <= pt.wl;
    in_wr <= pt.wr;
    in_nx <= pt.nx;
    in_ny <= pt.ny;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  // Return once the port is back to idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 5'(idx) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Drain the pipeline before touching the mean flow.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic edge_point_t uniform_point(q_t v, logic signed [17:0] nx,
                                                logic signed [17:0] ny);
    edge_point_t pt;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      pt.wl[k] = v;
      pt.wr[k] = -v;
    end
    pt.nx = nx;
    pt.ny = ny;
    return pt;
  endfunction

  // Mostly modest, physically plausible states; a share uses the full range.
  function automatic edge_point_t random_point();
    edge_point_t pt;
    int mode;
    mode = $urandom_range(99);
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (mode < 65) begin
        pt.wl[k] = q_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        pt.wr[k] = q_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      end else begin
        pt.wl[k] = q_t'($urandom());
        pt.wr[k] = q_t'($urandom());
      end
    end
    if (mode < 40) begin
      pt.nx = 18'($signed($urandom_range(0, 131072)) - 65536);
      pt.ny = 18'($signed($urandom_range(0, 131072)) - 65536);
    end else if (mode < 65) begin
      pt.nx = ($urandom_range(1)) ? 18'sd65536 : -18'sd65536;
      pt.ny = '0;
      if ($urandom_range(1)) begin
        pt.ny = pt.nx;
        pt.nx = '0;
      end
    end else begin
      pt.nx = 18'($urandom());
      pt.ny = 18'($urandom());
    end
    return pt;
  endfunction

  initial begin
    logic [31:0] settings [5][5];
    int          phase_idle [6];
    edge_point_t pt;
    settings[0] = '{32'd65536, 32'd520127, 32'd32768, 32'hFFFF_B333, 32'd91750};
    settings[1] = '{32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd524287};
    settings[2] = '{32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65536};
    settings[3] = '{32'd1, 32'd65536, 32'hFFFF_0000, 32'd65536, 32'd262144};
    settings[4] = '{32'h0001_8000, 32'h0003_0000, 32'd13107, 32'hFFFF_0000, 32'd98304};
    phase_idle = '{0, 67, 19, 67, 0, 19};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under the reset mean flow.
    idle_pct = 0;
    send_point(uniform_point(q_t'(0), 18'sd65536, 18'sd0));
    send_point(uniform_point(Q_MAX, 18'sd65536, 18'sd0));
    send_point(uniform_point(Q_MIN, 18'sd0, 18'sd65536));
    send_point(uniform_point(Q_MAX, -18'sd65536, -18'sd65536));
    send_point(uniform_point(Q_MIN, 18'sd131071, -18'sd131072));
    send_point(uniform_point(q_t'(65536), 18'sd46341, 18'sd46341));
    send_point(uniform_point(q_t'(-65536), -18'sd46341, 18'sd46341));
    send_point(uniform_point(q_t'(1), 18'sd0, 18'sd0));
    send_point(uniform_point(q_t'(-1), -18'sd131072, -18'sd131072));
    pt = uniform_point(Q_MAX, 18'sd65536, 18'sd0);
    pt.wr = pt.wl;
    send_point(pt);
    pt = uniform_point(Q_MIN, 18'sd131071, 18'sd131071);
    pt.wr = pt.wl;
    send_point(pt);
    for (int k = 0; k < NUM_FIELDS; k++) begin
      pt = uniform_point(q_t'(0), 18'sd65536, 18'sd0);
      pt.wl[k] = Q_MAX;
      pt.wr[k] = Q_MIN;
      send_point(pt);
      pt.wl[k] = Q_MIN;
      pt.wr[k] = Q_MAX;
      pt.nx = -18'sd65536;
      send_point(pt);
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        // Each write restarts the unit's own recalculation; start waits on busy.
        for (int r = 0; r < 5; r++) begin
          write_reg(3'(r), (ph == 5) ? (r == 4 ? 32'($urandom_range(65536, 262144))
                                                : ($urandom() & 32'h00FF_FFFF))
                                     : settings[ph - 1][r]);
        end
      end
      idle_pct = phase_idle[ph];
      for (int i = 0; i < 65; i++) send_point(random_point());
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
